@@ rtl/kfi_pkg.sv @@
// ----------------------------------------------------------------------------
// kfi_pkg
// Types and constants shared by the keyboard FIFO interface files.
// ----------------------------------------------------------------------------
package kfi_pkg;

    localparam logic [1:0] MODE_POST  = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;

    localparam int KEY_BITS = 16;

    typedef struct packed {
        logic [1:0]          mode;
        logic                addr_odd;
        logic [KEY_BITS-1:0] key_code;
    } t_kfi_in;

    typedef struct packed {
        logic signed [7:0] read_value;
        logic              irq_pending;
        logic              code_accepted;
    } t_kfi_out;

endpackage

@@ rtl/kfi_ram.sv @@
// ----------------------------------------------------------------------------
// kfi_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module kfi_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

@@ rtl/keyboard_fifo_interface.sv @@
// ----------------------------------------------------------------------------
// keyboard_fifo_interface
// Ring of key codes with a bus-style status/data view and pop on write.
//
// Usage: drive i_item and raise start; a beat is taken at the clock edge
// where start is high and busy is low. The item is a key post, a bus read
// or a bus write. busy stays high for one cycle after the beat, and in that
// cycle strobe is high for exactly one cycle with o_result valid. The
// receiver cannot hold results off; a result not captured is lost.
// The result comes in the cycle after the beat, and no new item is taken
// while busy: the head slot is read from the code RAM at the beat edge and the
// RAM's registered read port delivers it in the following cycle.
// The ring holds at most RING_SLOTS-1 codes; posts to a full ring drop.
// Reset clears the head and tail pointers and the per-slot valid bits, so
// slots never written read as zero. No clearing pass is needed; the block
// can take a beat in the first cycle after reset.
// ----------------------------------------------------------------------------
module keyboard_fifo_interface
    import kfi_pkg::*;
#(
    parameter int RING_SLOTS = 16,
    parameter int CODE_BITS  = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_kfi_in  i_item,
    output logic     strobe,
    output t_kfi_out o_result
);

    localparam int IDX_BITS = $clog2(RING_SLOTS);
    localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(RING_SLOTS - 1);

    logic                  r_busy;
    logic [IDX_BITS-1:0]   r_head;
    logic [IDX_BITS-1:0]   r_tail;
    logic [RING_SLOTS-1:0] r_valid;
    logic                  r_head_valid;
    logic                  r_post_ok;
    t_kfi_in               r_item;

    logic [IDX_BITS-1:0]   n_head;
    logic [IDX_BITS-1:0]   n_tail;
    logic [IDX_BITS-1:0]   w_tail_next;
    logic [IDX_BITS-1:0]   w_head_next;
    logic                  w_accept;
    logic                  w_empty;
    logic                  w_full;
    logic                  w_we;
    logic [31:0]           w_code_ext;
    logic [CODE_BITS-1:0]  w_code;
    logic [CODE_BITS-1:0]  w_rdata;
    logic [CODE_BITS-1:0]  w_head_code;
    logic [7:0]            w_status;

    assign w_accept    = start && !r_busy;
    assign w_tail_next = (r_tail == LAST_IDX) ? '0 : r_tail + 1'b1;
    assign w_head_next = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
    assign w_empty     = (r_head == r_tail);
    assign w_full      = (w_tail_next == r_head);
    assign w_we        = w_accept && (i_item.mode == MODE_POST) && !w_full;
    assign w_code_ext  = {{(32 - KEY_BITS){1'b0}}, i_item.key_code};
    assign w_code      = w_code_ext[CODE_BITS-1:0];

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        if (w_we) begin
            n_tail = w_tail_next;
        end
        if (w_accept && (i_item.mode == MODE_WRITE) && i_item.addr_odd && !w_empty) begin
            n_head = w_head_next;
        end
    end

    kfi_ram #(
        .WIDTH (CODE_BITS),
        .DEPTH (RING_SLOTS)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_tail),
        .i_wdata (w_code),
        .i_re    (w_accept),
        .i_raddr (r_head),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_head  <= '0;
            r_tail  <= '0;
            r_valid <= '0;
        end else begin
            r_busy <= w_accept;
            r_head <= n_head;
            r_tail <= n_tail;
            if (w_we) begin
                r_valid[r_tail] <= 1'b1;
            end
        end
        if (w_accept) begin
            r_item       <= i_item;
            r_head_valid <= r_valid[r_head];
            r_post_ok    <= w_we;
        end
    end

    assign w_head_code = w_rdata & {CODE_BITS{r_head_valid}};
    assign w_status    = {w_head_code[CODE_BITS-1:CODE_BITS-2], 4'b0000, w_full, w_empty};

    always_comb begin
        o_result.read_value    = '0;
        o_result.irq_pending   = !w_empty;
        o_result.code_accepted = 1'b0;
        case (r_item.mode)
            MODE_POST:  o_result.code_accepted = r_post_ok;
            MODE_READ:  o_result.read_value = r_item.addr_odd ? w_head_code[7:0] : w_status;
            default:    o_result.read_value = '0;
        endcase
    end

    assign busy   = r_busy;
    assign strobe = r_busy;

endmodule

@@ rtl/kfi_checker.sv @@
// ----------------------------------------------------------------------------
// kfi_checker
// Port-level checks on the keyboard FIFO interface, bound to the top level.
// ----------------------------------------------------------------------------
module kfi_checker
    import kfi_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     start,
    input logic     busy,
    input t_kfi_in  i_item,
    input logic     strobe,
    input t_kfi_out o_result
);

    logic w_beat;
    assign w_beat = start && !busy;

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_beat |=> strobe)
        else $error("no result after an accepted beat");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        strobe |=> !strobe)
        else $error("result strobe held for more than one cycle");

    a_stored_sets_irq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        strobe && o_result.code_accepted |-> o_result.irq_pending)
        else $error("stored code without interrupt request");

    a_non_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_beat && (i_item.mode != MODE_READ) |=> (o_result.read_value == 8'sd0))
        else $error("nonzero read value on a non-read beat");

    a_non_post_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_beat && (i_item.mode != MODE_POST) |=> !o_result.code_accepted)
        else $error("accept flag on a non-post beat");

endmodule

bind keyboard_fifo_interface kfi_checker u_kfi_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .strobe   (strobe),
    .o_result (o_result)
);

@@ test/keyboard_fifo_interface_tb.sv @@
// ----------------------------------------------------------------------------
// keyboard_fifo_interface_tb
// Self-checking bench for the keyboard FIFO interface: a directed opening
// (empty/full status, stale head reads, pops and posts at the limits) and
// then random bursts of fills, drains and mixed bus traffic. A ring model
// in the bench predicts every result; the monitor checks each strobed beat.
// ----------------------------------------------------------------------------
module keyboard_fifo_interface_tb
    import kfi_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_NONE   = 2'd3;
    localparam logic       ADDR_STATUS = 1'b0;
    localparam logic       ADDR_DATA   = 1'b1;
    localparam int         NUM_ITEMS   = 1450;
    localparam int         IDLE_LIMIT  = 2000;
    localparam int         DRAIN_WAIT  = 4;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     start   = 1'b0;
    t_kfi_in  i_item  = '0;
    logic     busy;
    logic     strobe;
    t_kfi_out o_result;

    t_kfi_in  pending_items[$];
    t_kfi_out expected_results[$];

    logic [KEY_BITS-1:0] key_ring [16];
    logic [3:0]          ring_head;
    logic [3:0]          ring_tail;

    int  gap_left;
    bit  no_gap_run;
    int  mismatches;
    int  idle_cycles;
    int  codes_stored, codes_dropped, bus_reads, pops_done, full_reads, results_seen;

    keyboard_fifo_interface uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .strobe   (strobe),
        .o_result (o_result)
    );

    always #1 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    function automatic t_kfi_out predict_key_beat(input t_kfi_in item);
        t_kfi_out res;
        logic     is_empty;
        logic     is_full;
        is_empty = (ring_head == ring_tail);
        is_full  = ((ring_tail + 4'd1) == ring_head);
        res      = '0;
        case (item.mode)
            MODE_POST: begin
                if (!is_full) begin
                    key_ring[ring_tail] = item.key_code;
                    ring_tail           = ring_tail + 4'd1;
                    res.code_accepted   = 1'b1;
                    codes_stored++;
                end else begin
                    codes_dropped++;
                end
            end
            MODE_READ: begin
                bus_reads++;
                if (item.addr_odd == ADDR_DATA) begin
                    res.read_value = key_ring[ring_head][7:0];
                end else begin
                    res.read_value = {key_ring[ring_head][KEY_BITS-1:KEY_BITS-2],
                                      4'b0000, is_full, is_empty};
                    if (is_full) full_reads++;
                end
            end
            MODE_WRITE: begin
                if (item.addr_odd == ADDR_DATA && !is_empty) begin
                    ring_head = ring_head + 4'd1;
                    pops_done++;
                end
            end
            default: ;
        endcase
        res.irq_pending = (ring_head != ring_tail);
        return res;
    endfunction

    function automatic int draw_gap();
        if ($urandom_range(0, 63) == 0) no_gap_run = !no_gap_run;
        return no_gap_run ? 0 : int'($urandom_range(0, 9));
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start     <= 1'b0;
            gap_left   = draw_gap();
            ring_head  = '0;
            ring_tail  = '0;
            foreach (key_ring[k]) key_ring[k] = '0;
        end else if (!start || !busy) begin
            if (start) begin
                expected_results.push_back(predict_key_beat(i_item));
                gap_left = draw_gap();
            end
            if (gap_left == 0 && pending_items.size() != 0) begin
                i_item <= pending_items.pop_front();
                start  <= 1'b1;
            end else begin
                start <= 1'b0;
                if (gap_left != 0) gap_left--;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_kfi_out want;
        if (i_rst_n && strobe) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                want = expected_results.pop_front();
                if (o_result.read_value !== want.read_value)
                    report_mismatch($sformatf("read_value %h, want %h",
                                              o_result.read_value, want.read_value));
                if (o_result.irq_pending !== want.irq_pending)
                    report_mismatch($sformatf("irq_pending %b, want %b",
                                              o_result.irq_pending, want.irq_pending));
                if (o_result.code_accepted !== want.code_accepted)
                    report_mismatch($sformatf("code_accepted %b, want %b",
                                              o_result.code_accepted, want.code_accepted));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || strobe) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic push_item(input logic [1:0] mode, input logic odd,
                             input logic [KEY_BITS-1:0] code);
        t_kfi_in item;
        item.mode     = mode;
        item.addr_odd = odd;
        item.key_code = code;
        pending_items.push_back(item);
    endtask

    function automatic logic [KEY_BITS-1:0] rand_code();
        return KEY_BITS'($urandom);
    endfunction

    initial begin
        int queued;
        int burst_len;
        int kind;
        logic [1:0] mode;

        // directed: empty ring, ignored accesses, one code through, fill to full
        push_item(MODE_READ,  ADDR_STATUS, 16'h0000);
        push_item(MODE_READ,  ADDR_DATA,   16'hFFFF);
        push_item(MODE_WRITE, ADDR_DATA,   16'hFFFF);
        push_item(MODE_WRITE, ADDR_STATUS, 16'h0000);
        push_item(MODE_NONE,  ADDR_DATA,   16'hFFFF);
        push_item(MODE_POST,  ADDR_STATUS, 16'hC0FF);
        push_item(MODE_READ,  ADDR_STATUS, 16'h0000);
        push_item(MODE_READ,  ADDR_DATA,   16'h0000);
        push_item(MODE_WRITE, ADDR_DATA,   16'h0000);
        push_item(MODE_READ,  ADDR_DATA,   16'h0000);
        push_item(MODE_POST,  ADDR_DATA,   16'hFFFF);
        push_item(MODE_POST,  ADDR_STATUS, 16'h0000);
        for (int k = 0; k < 13; k++)
            push_item(MODE_POST, ADDR_STATUS, 16'h4000 + 16'(k * 16'h1357));
        push_item(MODE_READ,  ADDR_STATUS, 16'h0000);

        queued = 0;
        while (queued < NUM_ITEMS) begin
            kind = $urandom_range(0, 9);
            if (kind < 3) begin
                burst_len = $urandom_range(1, 20);
                for (int k = 0; k < burst_len; k++)
                    push_item(MODE_POST, 1'($urandom), rand_code());
                queued += burst_len;
            end else if (kind < 7) begin
                burst_len = $urandom_range(1, 18);
                for (int k = 0; k < burst_len; k++) begin
                    if ($urandom_range(0, 3) != 0) begin
                        push_item(MODE_READ, ADDR_STATUS, rand_code());
                        push_item(MODE_READ, ADDR_DATA, rand_code());
                        queued += 2;
                    end
                    push_item(MODE_WRITE, ADDR_DATA, rand_code());
                    queued++;
                end
            end else begin
                burst_len = $urandom_range(5, 20);
                for (int k = 0; k < burst_len; k++) begin
                    mode = ($urandom_range(0, 15) == 0) ? MODE_NONE
                                                        : 2'($urandom_range(0, 2));
                    push_item(mode, 1'($urandom), rand_code());
                    if (mode != MODE_NONE) queued++;
                end
            end
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || start || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("checked %0d results: %0d codes stored, %0d dropped on a full ring",
                 results_seen, codes_stored, codes_dropped);
        $display("%0d bus reads (%0d status reads while full), %0d pops",
                 bus_reads, full_reads, pops_done);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
